### rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the stopwatch lap timer
// Transaction payloads, command codes and the millisecond constants used by
// the state update and by the time split pipeline.
// ----------------------------------------------------------------------------
package slt_pkg;

	// Millisecond quantities are 29 bits wide.
	typedef logic [28:0] ms_t;

	// Command codes carried in the cmd field.
	localparam logic [3:0] CMD_TICK     = 4'd0;
	localparam logic [3:0] CMD_STARTSTP = 4'd1;
	localparam logic [3:0] CMD_LAP      = 4'd2;
	localparam logic [3:0] CMD_CLEAR    = 4'd3;
	localparam logic [3:0] CMD_WHR_UP   = 4'd4;
	localparam logic [3:0] CMD_WHR_DN   = 4'd5;
	localparam logic [3:0] CMD_WMIN_UP  = 4'd6;
	localparam logic [3:0] CMD_WMIN_DN  = 4'd7;
	localparam logic [3:0] CMD_WSEC_UP  = 4'd8;
	localparam logic [3:0] CMD_WSEC_DN  = 4'd9;

	// Time units in milliseconds.
	localparam ms_t MS_HOUR  = 29'd3600000;
	localparam ms_t MS_MIN   = 29'd60000;
	localparam ms_t MS_SEC   = 29'd1000;
	localparam ms_t MS_CENTI = 29'd10;

	// Wrap point of the total (99:59:59.990) and warning threshold limits.
	localparam ms_t TOTAL_MAX   = 29'd359999990;
	localparam ms_t WARN_RESET  = 29'd5000;
	localparam ms_t WARN_MAX    = 29'd360000000;
	localparam ms_t HOUR_UP_MAX = 29'd356400000;
	localparam ms_t MIN_UP_MAX  = 29'd3540000;
	localparam ms_t SEC_UP_LIM  = 29'd59000;

	// Field widths of the split time.
	localparam int unsigned HOURS_W = 7;
	localparam int unsigned MINS_W  = 6;
	localparam int unsigned SECS_W  = 6;
	localparam int unsigned CENTS_W = 7;

	// Input transaction payload.
	typedef struct packed {
		logic [3:0]  cmd;
		logic [15:0] elapsed_ms;
		logic [4:0]  lap_index;
	} in_t;

	// Result transaction payload.
	typedef struct packed {
		ms_t         total_ms;
		logic [6:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [6:0]  centiseconds;
		logic        running;
		logic        warning_hit;
		ms_t         warning_ms;
		logic [4:0]  lap_count;
		logic [15:0] lap_number;
		ms_t         lap_value;
		logic        lap_valid;
	} out_t;

	// Handoff from the state stage to the split pipeline.
	typedef struct packed {
		logic vld;
		out_t res;
	} stage_t;

endpackage

### rtl/core/slt_in_if.sv
// ----------------------------------------------------------------------------
// slt_in_if: event channel of the stopwatch lap timer
// Valid/ready channel that carries one event per transaction.
// ----------------------------------------------------------------------------
interface slt_in_if;
	logic          valid;
	logic          ready;
	slt_pkg::in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/slt_out_if.sv
// ----------------------------------------------------------------------------
// slt_out_if: result channel of the stopwatch lap timer
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface slt_out_if;
	logic          valid;
	logic          ready;
	slt_pkg::out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/slt_core.sv
// ----------------------------------------------------------------------------
// slt_core: event state update and lap memory
// Updates the stopwatch registers once per accepted event, pushes laps into
// a ring-addressed memory and reads the requested lap in the same cycle.
// ----------------------------------------------------------------------------
module slt_core #(
	parameter int unsigned LAP_DEPTH = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  slt_pkg::in_t    in_data,
	input  logic            take,
	output slt_pkg::stage_t stage
);

	localparam int unsigned AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
	localparam int unsigned HW = $clog2(LAP_DEPTH + 1);
	localparam int unsigned SW = $clog2(2 * LAP_DEPTH + 32);

	// Architectural state.
	logic          run_q;
	slt_pkg::ms_t  total_q;
	slt_pkg::ms_t  warn_q;
	logic [15:0]   num_q;
	logic [HW-1:0] held_q;
	logic [AW-1:0] head_q;

	// Next-state values.
	logic          run_n;
	slt_pkg::ms_t  tot_n;
	slt_pkg::ms_t  tot_w;
	slt_pkg::ms_t  warn_n;
	logic [15:0]   num_n;
	logic [HW-1:0] held_n;
	logic [AW-1:0] head_n;
	logic          push;
	logic          hit;
	logic          lap_ok;
	logic [SW-1:0] sum;
	logic [AW-1:0] rd_addr;
	logic          accept;

	// Lap memory and its read stage.
	slt_pkg::ms_t  mem [LAP_DEPTH];
	slt_pkg::ms_t  rd_s1;
	slt_pkg::ms_t  wdata_s1;
	logic          fwd_s1;
	logic          vld_s1;
	slt_pkg::out_t res_s1;

	assign in_ready = !vld_s1 || take;
	assign accept   = in_valid && in_ready;

	// Next state for the event and the address of the requested lap.
	always_comb begin
		run_n  = run_q;
		tot_n  = total_q;
		warn_n = warn_q;
		num_n  = num_q;
		held_n = held_q;
		head_n = head_q;
		push   = 1'b0;
		unique case (in_data.cmd)
			slt_pkg::CMD_TICK: begin
				if (run_q) begin
					tot_n = total_q + slt_pkg::ms_t'(in_data.elapsed_ms);
				end
			end
			slt_pkg::CMD_STARTSTP: begin
				run_n = !run_q;
			end
			slt_pkg::CMD_LAP: begin
				push   = 1'b1;
				head_n = (head_q == AW'(LAP_DEPTH - 1)) ? '0 : head_q + 1'b1;
				num_n  = num_q + 16'd1;
				if (held_q < HW'(LAP_DEPTH)) begin
					held_n = held_q + 1'b1;
				end
			end
			slt_pkg::CMD_CLEAR: begin
				tot_n  = '0;
				held_n = '0;
				num_n  = '0;
				run_n  = 1'b0;
			end
			slt_pkg::CMD_WHR_UP: begin
				if (warn_q <= slt_pkg::HOUR_UP_MAX) begin
					warn_n = warn_q + slt_pkg::MS_HOUR;
				end
			end
			slt_pkg::CMD_WHR_DN: begin
				if (warn_q >= slt_pkg::MS_HOUR) begin
					warn_n = warn_q - slt_pkg::MS_HOUR;
				end
			end
			slt_pkg::CMD_WMIN_UP: begin
				if (warn_q <= slt_pkg::MIN_UP_MAX) begin
					warn_n = warn_q + slt_pkg::MS_MIN;
				end
			end
			slt_pkg::CMD_WMIN_DN: begin
				if (warn_q >= slt_pkg::MS_MIN) begin
					warn_n = warn_q - slt_pkg::MS_MIN;
				end
			end
			slt_pkg::CMD_WSEC_UP: begin
				if (warn_q < slt_pkg::SEC_UP_LIM) begin
					warn_n = warn_q + slt_pkg::MS_SEC;
				end
			end
			slt_pkg::CMD_WSEC_DN: begin
				if (warn_q > slt_pkg::MS_SEC) begin
					warn_n = warn_q - slt_pkg::MS_SEC;
				end
			end
			default: begin
			end
		endcase

		// The warning compare sees the total before it wraps.
		hit   = warn_n < tot_n;
		tot_w = (tot_n > slt_pkg::TOTAL_MAX) ? '0 : tot_n;

		// Newest lap sits just below the head; walk back by the index.
		lap_ok = (SW'(in_data.lap_index) < SW'(held_n)) &&
			(SW'(in_data.lap_index) < SW'(LAP_DEPTH));
		sum = SW'(head_n) + SW'(LAP_DEPTH - 1) - SW'(in_data.lap_index);
		if (sum >= SW'(LAP_DEPTH)) begin
			sum = sum - SW'(LAP_DEPTH);
		end
		rd_addr = lap_ok ? sum[AW-1:0] : '0;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			total_q <= '0;
			warn_q  <= slt_pkg::WARN_RESET;
			num_q   <= '0;
			held_q  <= '0;
			head_q  <= '0;
		end else if (accept) begin
			run_q   <= run_n;
			total_q <= tot_w;
			warn_q  <= warn_n;
			num_q   <= num_n;
			held_q  <= held_n;
			head_q  <= head_n;
		end
	end

	// Lap memory write port.
	always_ff @(posedge clk) begin
		if (accept && push) begin
			mem[head_q] <= total_q;
		end
	end

	// Lap memory read port and the result register of this stage.
	always_ff @(posedge clk) begin
		if (in_ready) begin
			rd_s1                 <= mem[rd_addr];
			wdata_s1              <= total_q;
			fwd_s1                <= push && (rd_addr == head_q);
			res_s1.total_ms       <= tot_w;
			res_s1.hours          <= '0;
			res_s1.minutes        <= '0;
			res_s1.seconds        <= '0;
			res_s1.centiseconds   <= '0;
			res_s1.running        <= run_n;
			res_s1.warning_hit    <= hit;
			res_s1.warning_ms     <= warn_n;
			res_s1.lap_count      <= 5'(held_n);
			res_s1.lap_number     <= num_n;
			res_s1.lap_value      <= '0;
			res_s1.lap_valid      <= lap_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// A lap read of the entry written in the same cycle takes the new value.
	always_comb begin
		stage.vld = vld_s1;
		stage.res = res_s1;
		if (!res_s1.lap_valid) begin
			stage.res.lap_value = '0;
		end else if (fwd_s1) begin
			stage.res.lap_value = wdata_s1;
		end else begin
			stage.res.lap_value = rd_s1;
		end
	end

endmodule

### rtl/core/slt_cdiv.sv
// ----------------------------------------------------------------------------
// slt_cdiv: two-stage division by a constant
// The first stage estimates the quotient with a reciprocal multiply; the
// second computes the remainder and corrects the estimate by at most one.
// ----------------------------------------------------------------------------
module slt_cdiv #(
	parameter int unsigned XW  = 29,
	parameter int unsigned DIV = 10,
	parameter int unsigned QW  = 7,
	parameter int unsigned RW  = $clog2(DIV)
) (
	input  logic          clk,
	input  logic          en_a,
	input  logic          en_b,
	input  logic [XW-1:0] x,
	output logic [QW-1:0] q,
	output logic [RW-1:0] r
);

	localparam longint unsigned MUL = (64'd1 << XW) / DIV;
	localparam int unsigned     MW  = $clog2(MUL + 1);

	logic [XW+MW-1:0] prod;
	logic [XW-1:0]    x_s1;
	logic [QW-1:0]    q0_s1;
	logic [XW-1:0]    qd;
	logic [XW-1:0]    rem;
	logic             over;

	// Reciprocal estimate, never above the true quotient and at most one below.
	assign prod = {{MW{1'b0}}, x} * {{XW{1'b0}}, MW'(MUL)};

	always_ff @(posedge clk) begin
		if (en_a) begin
			x_s1  <= x;
			q0_s1 <= prod[XW +: QW];
		end
	end

	// Remainder of the estimate and its single correction step.
	always_comb begin
		qd   = XW'(q0_s1) * XW'(DIV);
		rem  = x_s1 - qd;
		over = rem >= XW'(DIV);
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			if (over) begin
				q <= q0_s1 + 1'b1;
				r <= RW'(rem - XW'(DIV));
			end else begin
				q <= q0_s1;
				r <= RW'(rem);
			end
		end
	end

endmodule

### rtl/core/slt_split.sv
// ----------------------------------------------------------------------------
// slt_split: hours, minutes, seconds and hundredths of the total
// Eight-stage pipeline of four constant dividers; each stage holds its
// result until the next stage or the output can take it.
// ----------------------------------------------------------------------------
module slt_split (
	input  logic            clk,
	input  logic            arst_n,
	input  slt_pkg::stage_t stage,
	output logic            take,
	output logic            out_valid,
	input  logic            out_ready,
	output slt_pkg::out_t   out_data
);

	localparam int unsigned NSTG = 8;

	logic [NSTG-1:0]             vld_q;
	slt_pkg::out_t               res_q [NSTG];
	slt_pkg::out_t               res_d [NSTG];
	logic [NSTG:0]               en;
	logic [slt_pkg::HOURS_W-1:0] hrs;
	logic [slt_pkg::MINS_W-1:0]  mins;
	logic [slt_pkg::SECS_W-1:0]  secs;
	logic [slt_pkg::CENTS_W-1:0] cents;
	logic [21:0]                 rem_h;
	logic [15:0]                 rem_m;
	logic [9:0]                  rem_s;

	// A stage loads when it is empty or its content moves on.
	always_comb begin
		en[NSTG] = out_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign take = en[0];

	// Total to hours and remainder within the hour.
	slt_cdiv #(
		.XW(29), .DIV(slt_pkg::MS_HOUR), .QW(slt_pkg::HOURS_W), .RW(22)
	) u_div_hour (
		.clk(clk), .en_a(en[0]), .en_b(en[1]),
		.x(stage.res.total_ms), .q(hrs), .r(rem_h)
	);

	// Remainder within the hour to minutes.
	slt_cdiv #(
		.XW(22), .DIV(slt_pkg::MS_MIN), .QW(slt_pkg::MINS_W), .RW(16)
	) u_div_min (
		.clk(clk), .en_a(en[2]), .en_b(en[3]),
		.x(rem_h), .q(mins), .r(rem_m)
	);

	// Remainder within the minute to seconds.
	slt_cdiv #(
		.XW(16), .DIV(slt_pkg::MS_SEC), .QW(slt_pkg::SECS_W), .RW(10)
	) u_div_sec (
		.clk(clk), .en_a(en[4]), .en_b(en[5]),
		.x(rem_m), .q(secs), .r(rem_s)
	);

	// Remainder within the second to hundredths.
	slt_cdiv #(
		.XW(10), .DIV(slt_pkg::MS_CENTI), .QW(slt_pkg::CENTS_W), .RW(4)
	) u_div_cent (
		.clk(clk), .en_a(en[6]), .en_b(en[7]),
		.x(rem_s), .q(cents), .r()
	);

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= stage.vld;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Next content of each stage; each quotient joins as it becomes ready.
	always_comb begin
		res_d[0] = stage.res;
		for (int k = 1; k < NSTG; k++) begin
			res_d[k] = res_q[k-1];
		end
		res_d[2].hours   = hrs;
		res_d[4].minutes = mins;
		res_d[6].seconds = secs;
	end

	// Result fields travel along the stages.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NSTG; k++) begin
			if (en[k]) begin
				res_q[k] <= res_d[k];
			end
		end
	end

	// Output register is the last stage together with the last divider.
	assign out_valid = vld_q[NSTG-1];

	always_comb begin
		out_data              = res_q[NSTG-1];
		out_data.centiseconds = cents;
	end

endmodule

### rtl/core/stopwatch_lap_timer_top.sv
// ----------------------------------------------------------------------------
// stopwatch_lap_timer_top: millisecond stopwatch with lap memory
// Events in, one result per event out, with a newest-first lap store.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on in_ch carries one event: a tick with the milliseconds
// passed, start/pause, lap, clear, or a nudge of the warning threshold. Each
// event yields exactly one transaction on out_ch with the total, its split
// into hours, minutes, seconds and hundredths, the warning state, the lap
// counters and the stored lap selected by lap_index.
// One event is accepted per clock cycle while in_ch.ready is high. The stopwatch
// registers are updated in the accept cycle and the lap memory has one write
// and one read port, so consecutive events never wait on each other. A result
// passes the state stage, which does the state update and the lap memory
// read, then the stages of the four two-stage constant dividers of the split.
// When out_ch.ready is low, results queue up in the pipeline stages and
// in_ch.ready drops only once every stage holds a result.
// arst_n clears the stopwatch registers, sets the warning threshold to
// WARN_RESET and empties the pipeline; the lap memory keeps its contents but no lap is valid until new laps are taken.
// ----------------------------------------------------------------------------
module stopwatch_lap_timer_top #(
	parameter int unsigned LAP_DEPTH = 20
) (
	input  logic     clk,
	input  logic     arst_n,
	slt_in_if.sink   in_ch,
	slt_out_if.source out_ch
);

	slt_pkg::stage_t stage;
	logic            take;
	logic            in_ready;
	logic            out_valid;
	slt_pkg::out_t   out_data;

	// Event state update and lap memory.
	slt_core #(
		.LAP_DEPTH(LAP_DEPTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ready),
		.in_data(in_ch.data),
		.take(take),
		.stage(stage)
	);

	// Time split pipeline and output register.
	slt_split u_split (
		.clk(clk),
		.arst_n(arst_n),
		.stage(stage),
		.take(take),
		.out_valid(out_valid),
		.out_ready(out_ch.ready),
		.out_data(out_data)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;
	assign out_ch.data  = out_data;

endmodule

### rtl/core/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker: port-level checks of the stopwatch lap timer
// Watches the result channel for held transactions and value ranges.
// ----------------------------------------------------------------------------
module slt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input slt_pkg::out_t out_data
);

	// A stalled result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The split of the total stays within clock-face ranges.
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.total_ms <= slt_pkg::TOTAL_MAX &&
			out_data.hours <= 7'd99 && out_data.minutes <= 6'd59 &&
			out_data.seconds <= 6'd59 && out_data.centiseconds <= 7'd99)
		else $error("time split out of range");

	// An invalid lap reports a zero value.
	a_lap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.lap_valid |-> out_data.lap_value == '0)
		else $error("invalid lap carries a value");

	// The warning threshold never leaves its bounds.
	a_warn_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.warning_ms <= slt_pkg::WARN_MAX)
		else $error("warning threshold out of range");

endmodule

bind stopwatch_lap_timer_top slt_checker u_slt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data(out_ch.data)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stopwatch lap timer
// Drives events over the input channel with random gaps, stalls the result
// channel at random, and predicts every result in a scoreboard that keeps
// its own copy of the stopwatch state and the newest-first lap store.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned LAPS = 20;

	// Codes that the block ignores apart from returning a result.
	localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;
	localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;

	// Keeps the predicted stopwatch state and the results still owed.
	class lap_timer_scoreboard;
		bit            running;
		int unsigned   total;
		int unsigned   threshold;
		logic [15:0]   lap_num;
		int unsigned   lap_cnt;
		slt_pkg::ms_t  laps[LAPS];
		slt_pkg::out_t expected_q[$];
		int unsigned   errors;

		function new();
			running = 1'b0;
			total = 0;
			threshold = 32'(slt_pkg::WARN_RESET);
			lap_num = '0;
			lap_cnt = 0;
			foreach (laps[i]) laps[i] = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Applies one accepted event to the state and queues its result.
		function void note_event(slt_pkg::in_t ev);
			slt_pkg::out_t r;
			bit hit;
			case (ev.cmd)
				slt_pkg::CMD_TICK: if (running) total += 32'(ev.elapsed_ms);
				slt_pkg::CMD_STARTSTP: running = !running;
				slt_pkg::CMD_LAP: begin
					// Newest-first store: shift everything down, drop the oldest.
					for (int i = LAPS - 1; i > 0; i--) laps[i] = laps[i - 1];
					laps[0] = slt_pkg::ms_t'(total);
					lap_num = lap_num + 16'd1;
					if (lap_cnt < LAPS) lap_cnt++;
				end
				slt_pkg::CMD_CLEAR: begin
					total = 0;
					lap_cnt = 0;
					lap_num = '0;
					running = 1'b0;
				end
				slt_pkg::CMD_WHR_UP: begin
					if (threshold <= slt_pkg::HOUR_UP_MAX)
						threshold += 32'(slt_pkg::MS_HOUR);
				end
				slt_pkg::CMD_WHR_DN: begin
					if (threshold >= slt_pkg::MS_HOUR)
						threshold -= 32'(slt_pkg::MS_HOUR);
				end
				slt_pkg::CMD_WMIN_UP: begin
					if (threshold <= slt_pkg::MIN_UP_MAX)
						threshold += 32'(slt_pkg::MS_MIN);
				end
				slt_pkg::CMD_WMIN_DN: begin
					if (threshold >= slt_pkg::MS_MIN)
						threshold -= 32'(slt_pkg::MS_MIN);
				end
				slt_pkg::CMD_WSEC_UP: begin
					if (threshold < slt_pkg::SEC_UP_LIM)
						threshold += 32'(slt_pkg::MS_SEC);
				end
				slt_pkg::CMD_WSEC_DN: begin
					if (threshold > slt_pkg::MS_SEC)
						threshold -= 32'(slt_pkg::MS_SEC);
				end
				default: ;
			endcase

			// The warning compare sees the total before the wrap.
			hit = threshold < total;
			if (total > slt_pkg::TOTAL_MAX) begin
				total = 0;
			end

			r.total_ms = slt_pkg::ms_t'(total);
			r.hours = 7'(total / slt_pkg::MS_HOUR);
			r.minutes = 6'((total / slt_pkg::MS_MIN) % 60);
			r.seconds = 6'((total / slt_pkg::MS_SEC) % 60);
			r.centiseconds = 7'((total / slt_pkg::MS_CENTI) % 100);
			r.running = running;
			r.warning_hit = hit;
			r.warning_ms = slt_pkg::ms_t'(threshold);
			r.lap_count = 5'(lap_cnt);
			r.lap_number = lap_num;
			r.lap_valid = ev.lap_index < lap_cnt;
			r.lap_value = r.lap_valid ? laps[ev.lap_index] : '0;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100) $display("MISMATCH at %0t: %s", $time, msg);
		endtask

		task cmp(string name, longint unsigned got, longint unsigned want);
			if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		// Compares one accepted result with the oldest expectation.
		task check_result(slt_pkg::out_t got);
			slt_pkg::out_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with no event pending, total_ms %0d", got.total_ms));
				return;
			end
			want = expected_q.pop_front();
			cmp("total_ms", got.total_ms, want.total_ms);
			cmp("hours", got.hours, want.hours);
			cmp("minutes", got.minutes, want.minutes);
			cmp("seconds", got.seconds, want.seconds);
			cmp("centiseconds", got.centiseconds, want.centiseconds);
			cmp("running", got.running, want.running);
			cmp("warning_hit", got.warning_hit, want.warning_hit);
			cmp("warning_ms", got.warning_ms, want.warning_ms);
			cmp("lap_count", got.lap_count, want.lap_count);
			cmp("lap_number", got.lap_number, want.lap_number);
			cmp("lap_value", got.lap_value, want.lap_value);
			cmp("lap_valid", got.lap_valid, want.lap_valid);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	slt_in_if in_ch();
	slt_out_if out_ch();

	stopwatch_lap_timer_top #(.LAP_DEPTH(LAPS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	lap_timer_scoreboard sb;
	int unsigned sent = 0;
	bit steady = 1'b0;
	int unsigned hold_cnt = 0;
	bit out_took = 1'b0;

	always #5 clk = ~clk;

	// Result side: hold ready low for the drawn number of cycles after each transaction.
	always @(negedge clk) begin
		if (out_took) begin
			hold_cnt = steady ? 0 : $urandom_range(0, 3);
		end
		if (hold_cnt != 0) begin
			out_ch.ready <= 1'b0;
			hold_cnt = hold_cnt - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Every accepted result goes to the scoreboard.
	always @(posedge clk) begin
		out_took <= (arst_n === 1'b1) && (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
		if (arst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
			sb.check_result(out_ch.data);
		end
	end

	function automatic slt_pkg::in_t mk(logic [3:0] c, logic [15:0] ms, logic [4:0] idx);
		slt_pkg::in_t ev;
		ev.cmd = c;
		ev.elapsed_ms = ms;
		ev.lap_index = idx;
		return ev;
	endfunction

	function automatic logic [15:0] rand_ms();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly indexes around the number of held laps, sometimes anything.
	function automatic logic [4:0] pick_index();
		if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
		if (sb.lap_cnt != 0) return 5'($urandom_range(0, sb.lap_cnt));
		return 5'($urandom_range(0, LAPS - 1));
	endfunction

	function automatic slt_pkg::in_t rand_event();
		int unsigned w;
		logic [3:0] c;
		w = $urandom_range(0, 99);
		if (w < 40) c = slt_pkg::CMD_TICK;
		else if (w < 50) c = slt_pkg::CMD_STARTSTP;
		else if (w < 68) c = slt_pkg::CMD_LAP;
		else if (w < 71) c = slt_pkg::CMD_CLEAR;
		else if (w < 93) c = 4'($urandom_range(slt_pkg::CMD_WHR_UP, slt_pkg::CMD_WSEC_DN));
		else c = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
		return mk(c, rand_ms(), pick_index());
	endfunction

	// Presents one event after a random gap and waits for its transaction.
	task automatic send_event(slt_pkg::in_t ev);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.data <= ev;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_event(ev);
		sent++;
	endtask

	// Stops sending and waits until every owed result has arrived.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Random segments: mixed traffic, threshold bursts, lap bursts and noise.
	task automatic run_segments(int unsigned count);
		int unsigned stop_at;
		int unsigned len;
		logic [3:0] c;
		stop_at = sent + count;
		while (sent < stop_at) begin
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 7))
				0, 1, 2, 3, 4: begin
					len = $urandom_range(10, 40);
					repeat (len) send_event(rand_event());
				end
				5: begin
					// Long runs of one nudge reach the threshold bounds.
					c = 4'($urandom_range(slt_pkg::CMD_WHR_UP, slt_pkg::CMD_WSEC_DN));
					len = $urandom_range(20, 110);
					repeat (len) send_event(mk(c, rand_ms(), pick_index()));
				end
				6: begin
					// Runs of laps that can overflow the store and drop the oldest.
					if (!sb.running)
						send_event(mk(slt_pkg::CMD_STARTSTP, rand_ms(), pick_index()));
					len = $urandom_range(15, 30);
					repeat (len) begin
						send_event(mk(slt_pkg::CMD_TICK, rand_ms(), pick_index()));
						send_event(mk(slt_pkg::CMD_LAP, rand_ms(), pick_index()));
					end
				end
				default: begin
					len = $urandom_range(3, 8);
					repeat (len) begin
						c = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
						send_event(mk(c, rand_ms(), 5'($urandom_range(0, 31))));
					end
				end
			endcase
			if ($urandom_range(0, 5) == 0) drain();
		end
		steady = 1'b0;
	endtask

	initial begin
		slt_pkg::in_t directed[$];
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: paused tick, laps at zero, tick extremes, out-of-range index,
		// every threshold nudge including the refused ones, unused codes, and a
		// clear that leaves the store contents but empties the lap count.
		directed.push_back(mk(slt_pkg::CMD_TICK, 16'hFFFF, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_LAP, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_LAP, 16'd0, 5'd1));
		directed.push_back(mk(slt_pkg::CMD_STARTSTP, 16'd0, 5'd1));
		directed.push_back(mk(slt_pkg::CMD_TICK, 16'hFFFF, 5'd31));
		directed.push_back(mk(slt_pkg::CMD_TICK, 16'd0, 5'd2));
		directed.push_back(mk(slt_pkg::CMD_LAP, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_TICK, 16'd12345, 5'd2));
		directed.push_back(mk(slt_pkg::CMD_LAP, 16'd0, 5'd3));
		directed.push_back(mk(slt_pkg::CMD_STARTSTP, 16'd0, 5'd4));
		directed.push_back(mk(slt_pkg::CMD_TICK, 16'hFFFF, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_WHR_UP, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_WHR_DN, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_WHR_DN, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_WMIN_UP, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_WMIN_DN, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_WMIN_DN, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_WSEC_UP, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_WSEC_DN, 16'd0, 5'd0));
		directed.push_back(mk(CMD_FIRST_UNUSED, 16'hFFFF, 5'd19));
		directed.push_back(mk(CMD_LAST_UNUSED, 16'hFFFF, 5'd19));
		directed.push_back(mk(slt_pkg::CMD_CLEAR, 16'd0, 5'd0));
		directed.push_back(mk(slt_pkg::CMD_LAP, 16'd0, 5'd1));
		foreach (directed[i]) send_event(directed[i]);
		drain();

		run_segments(500);

		// Hold the sender until the pipeline is completely empty.
		drain();

		run_segments(500);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hard stop in case a result never shows up.
	initial begin
		#(5_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
